### design/slpa_pkg.sv
// shared types, codes and defaults for the slot pool allocator
package slpa_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_INDEX_W  = 4;
    localparam int USED_COUNT_W  = 5;

    typedef enum logic
    {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_NOT_USED  = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t                    cmd;
        logic [SLOT_INDEX_W-1:0] slot_index;
    } req_t;

    typedef struct packed
    {
        logic [SLOT_INDEX_W-1:0] granted_slot;
        status_t                 status;
        logic [USED_COUNT_W-1:0] used_count;
    } rsp_t;

endpackage

### design/slot_pool_allocator_top.sv
// slot pool allocator top level: sequencer, link memory and checks
//
// req channel (valid/ready) carries one command: acquire the head free slot,
// or release the slot named by slot_index. rsp channel returns exactly one
// result per command: granted slot, status and the in-use count after it.
// all slots sit on one doubly linked list kept in a single link memory
// (used flag, next and prev per slot); head, tail and count are registers.
// one command is worked on at a time. a transfer on req is followed by one
// read of the slot entry, then one link write per cycle on the single
// write port, then the result register is loaded: no link write for a refused
// command, one for a simple update, three for an acquire that moves the head
// slot to the tail, four for a release that unlinks a slot inside the list.
// after reset a clearing pass rebuilds the list with req_ready low. the
// result sits in an output register; while the receiver stalls the next
// command is still taken and runs up to its result, then waits until the
// previous result is transferred.
module slot_pool_allocator_top
    import slpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;
    localparam int EW = 2 * LW + 1;
    localparam int WW = 3 + IW + EW;

    typedef struct packed
    {
        logic          en_used;
        logic          en_next;
        logic          en_prev;
        logic [IW-1:0] addr;
        logic [EW-1:0] data;
    } wop_t;

    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic [WW-1:0] wr;
    wop_t          wop;

    assign wop = wop_t'(wr);

    slpa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr)
    );

    slpa_link_ram #(
        .SLOTS (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // link writes never overlap a command transfer
    a_no_write_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (wop.en_used || wop.en_next || wop.en_prev) |-> !(req_valid && req_ready))
        else $error("link write during command transfer");

    // one command in flight at a time
    a_single_item : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second command taken while busy");

    // only a successful acquire names a slot
    a_grant_zero_on_error : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STAT_OK) |-> (rsp.granted_slot == '0))
        else $error("slot granted with error status");

endmodule

### design/slpa_link_ram.sv
// link memory: per-slot used flag, next link and prev link, field write enables
module slpa_link_ram
    import slpa_pkg::*;
#(
    parameter  int SLOTS = SLOTS_DEFAULT,
    localparam int IW    = $clog2(SLOTS),
    localparam int LW    = IW + 1,
    localparam int EW    = 2 * LW + 1,
    localparam int WW    = 3 + IW + EW
)
(
    input  logic          clk,
    input  logic [WW-1:0] wr,
    input  logic [IW-1:0] rd_addr,
    output logic [EW-1:0] rd_data
);

    typedef struct packed
    {
        logic          used;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } entry_t;

    typedef struct packed
    {
        logic          en_used;
        logic          en_next;
        logic          en_prev;
        logic [IW-1:0] addr;
        entry_t        data;
    } wop_t;

    wop_t   wop;
    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    assign wop     = wop_t'(wr);
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wop.en_used)
        begin
            mem[wop.addr].used <= wop.data.used;
        end
        if (wop.en_next)
        begin
            mem[wop.addr].nxt <= wop.data.nxt;
        end
        if (wop.en_prev)
        begin
            mem[wop.addr].prv <= wop.data.prv;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### design/slpa_ctrl.sv
// sequencer: clearing pass, read of the slot entry, queued link writes, result register
module slpa_ctrl
    import slpa_pkg::*;
#(
    parameter  int SLOTS = SLOTS_DEFAULT,
    localparam int IW    = $clog2(SLOTS),
    localparam int LW    = IW + 1,
    localparam int CW    = $clog2(SLOTS + 1),
    localparam int EW    = 2 * LW + 1,
    localparam int WW    = 3 + IW + EW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  req_t          req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rsp_t          rsp,
    output logic [IW-1:0] rd_addr,
    input  logic [EW-1:0] rd_data,
    output logic [WW-1:0] wr
);

    localparam int          NOPS  = 4;
    localparam logic [LW-1:0] LNULL = LW'(SLOTS);

    typedef struct packed
    {
        logic          used;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } entry_t;

    typedef struct packed
    {
        logic          en_used;
        logic          en_next;
        logic          en_prev;
        logic [IW-1:0] addr;
        entry_t        data;
    } wop_t;

    typedef enum logic [2:0]
    {
        S_INIT,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] init_reg, init_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    opi_reg, opi_next;
    logic [2:0]    nops_reg, nops_next;
    logic          out_valid_reg, out_valid_next;

    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] sidx_reg, sidx_next;
    logic          sok_reg, sok_next;
    wop_t          ops_reg [NOPS];
    wop_t          ops_next [NOPS];
    rsp_t          res_reg, res_next;
    rsp_t          out_reg, out_next;

    entry_t        rd_e;
    wop_t          wop;

    assign rd_e      = entry_t'(rd_data);
    assign wr        = WW'(wop);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign rd_addr   = (req.cmd == CMD_RELEASE) ? IW'(req.slot_index) : head_reg;

    always_comb
    begin
        logic          fail;
        logic          relink;
        logic          not_head;
        logic          bok;
        logic          aok;
        logic [CW-1:0] cnt_new;

        state_next     = state_reg;
        init_next      = init_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        opi_next       = opi_reg;
        nops_next      = nops_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        sidx_next      = sidx_reg;
        sok_next       = sok_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        for (int i = 0; i < NOPS; i++)
        begin
            ops_next[i] = ops_reg[i];
        end
        wop      = '0;
        fail     = 1'b0;
        relink   = 1'b0;
        not_head = 1'b0;
        bok      = 1'b0;
        aok      = 1'b0;
        cnt_new  = count_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass: rebuild the reset list one entry per cycle
                wop.en_used   = 1'b1;
                wop.en_next   = 1'b1;
                wop.en_prev   = 1'b1;
                wop.addr      = init_reg;
                wop.data.used = 1'b0;
                wop.data.nxt  = LW'(init_reg) + LW'(1);
                wop.data.prv  = (init_reg == '0) ? LNULL : LW'(init_reg) - LW'(1);
                init_next     = init_reg + IW'(1);
                if (init_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    sidx_next  = IW'(req.slot_index);
                    sok_next   = (32'(req.slot_index) < 32'(SLOTS));
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                for (int i = 0; i < NOPS; i++)
                begin
                    ops_next[i] = '0;
                end
                if (cmd_reg == CMD_ACQUIRE)
                begin
                    fail   = (count_reg >= CW'(SLOTS)) || rd_e.used;
                    relink = (head_reg != tail_reg) && (rd_e.nxt < LNULL);
                    // head slot: mark used and, on relink, move it behind the tail
                    ops_next[0].en_used   = 1'b1;
                    ops_next[0].en_next   = relink;
                    ops_next[0].en_prev   = relink;
                    ops_next[0].addr      = head_reg;
                    ops_next[0].data.used = 1'b1;
                    ops_next[0].data.nxt  = LNULL;
                    ops_next[0].data.prv  = LW'(tail_reg);
                    ops_next[1].en_next   = relink;
                    ops_next[1].addr      = tail_reg;
                    ops_next[1].data.nxt  = LW'(head_reg);
                    ops_next[2].en_prev   = relink;
                    ops_next[2].addr      = rd_e.nxt[IW-1:0];
                    ops_next[2].data.prv  = LNULL;
                    nops_next = fail ? 3'd0 : (relink ? 3'd3 : 3'd1);
                    if (!fail)
                    begin
                        cnt_new = count_reg + CW'(1);
                        if (relink)
                        begin
                            head_next = rd_e.nxt[IW-1:0];
                            tail_next = head_reg;
                        end
                    end
                    res_next.granted_slot = fail ? '0 : SLOT_INDEX_W'(head_reg);
                    res_next.status       = fail ? STAT_EXHAUSTED : STAT_OK;
                end
                else
                begin
                    fail     = !sok_reg || !rd_e.used;
                    not_head = (sidx_reg != head_reg);
                    bok      = (rd_e.prv < LNULL);
                    aok      = (rd_e.nxt < LNULL);
                    if (not_head)
                    begin
                        // unlink from the neighbors, then push at the head
                        ops_next[0].en_next   = bok;
                        ops_next[0].addr      = rd_e.prv[IW-1:0];
                        ops_next[0].data.nxt  = aok ? rd_e.nxt : LNULL;
                        ops_next[1].en_prev   = bok && aok;
                        ops_next[1].addr      = rd_e.nxt[IW-1:0];
                        ops_next[1].data.prv  = rd_e.prv;
                        ops_next[2].en_used   = 1'b1;
                        ops_next[2].en_next   = 1'b1;
                        ops_next[2].en_prev   = 1'b1;
                        ops_next[2].addr      = sidx_reg;
                        ops_next[2].data.used = 1'b0;
                        ops_next[2].data.nxt  = LW'(head_reg);
                        ops_next[2].data.prv  = LNULL;
                        ops_next[3].en_prev   = 1'b1;
                        ops_next[3].addr      = head_reg;
                        ops_next[3].data.prv  = LW'(sidx_reg);
                    end
                    else
                    begin
                        ops_next[0].en_used   = 1'b1;
                        ops_next[0].addr      = sidx_reg;
                        ops_next[0].data.used = 1'b0;
                    end
                    nops_next = fail ? 3'd0 : (not_head ? 3'd4 : 3'd1);
                    if (!fail)
                    begin
                        if (count_reg != '0)
                        begin
                            cnt_new = count_reg - CW'(1);
                        end
                        if (not_head)
                        begin
                            head_next = sidx_reg;
                            if (bok && !aok)
                            begin
                                tail_next = rd_e.prv[IW-1:0];
                            end
                        end
                    end
                    res_next.granted_slot = '0;
                    res_next.status       = fail ? STAT_NOT_USED : STAT_OK;
                end
                count_next          = cnt_new;
                res_next.used_count = USED_COUNT_W'(cnt_new);
                opi_next            = '0;
                state_next          = fail ? S_DONE : S_WRITE;
            end
            S_WRITE:
            begin
                wop      = ops_reg[opi_reg];
                opi_next = opi_reg + 2'd1;
                if ({1'b0, opi_reg} + 3'd1 == nops_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= IW'(SLOTS - 1);
            count_reg     <= '0;
            opi_reg       <= '0;
            nops_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            opi_reg       <= opi_next;
            nops_reg      <= nops_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        sidx_reg <= sidx_next;
        sok_reg  <= sok_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        for (int i = 0; i < NOPS; i++)
        begin
            ops_reg[i] <= ops_next[i];
        end
    end

endmodule

### tb/slpa_checker.sv
// checker for the slot pool allocator: predicts each result and compares it
module slpa_checker
    import slpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    // shadow of the slot list: free slots from free_head, used ones up to busy_tail
    logic [LINK_W-1:0] fwd_link  [SLOTS];
    logic [LINK_W-1:0] back_link [SLOTS];
    logic              slot_busy [SLOTS];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] busy_tail;
    int                busy_count;
    rsp_t              owed_rsp [$];

    function automatic logic is_slot(logic [LINK_W-1:0] v);
        return int'(v) < SLOTS;
    endfunction

    function automatic rsp_t pool_step(req_t r);
        rsp_t              ans;
        logic [LINK_W-1:0] h;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] prv;
        logic [LINK_W-1:0] nxt;
        ans.granted_slot = '0;
        ans.status       = STAT_OK;
        if (r.cmd == CMD_ACQUIRE)
        begin
            h = free_head;
            if (busy_count >= SLOTS || !is_slot(h) || slot_busy[h])
                ans.status = STAT_EXHAUSTED;
            else
            begin
                slot_busy[h] = 1'b1;
                nxt = fwd_link[h];
                // taken slot goes from the head to the tail, if it can be relinked there
                if (h != busy_tail && is_slot(nxt) && is_slot(busy_tail))
                begin
                    fwd_link[h]         = NIL;
                    back_link[h]        = busy_tail;
                    fwd_link[busy_tail] = h;
                    busy_tail           = h;
                    free_head           = nxt;
                    back_link[nxt]      = NIL;
                end
                busy_count++;
                ans.granted_slot = h[SLOT_INDEX_W-1:0];
            end
        end
        else
        begin
            s = LINK_W'(r.slot_index);
            if (!is_slot(s) || !slot_busy[s])
                ans.status = STAT_NOT_USED;
            else
            begin
                slot_busy[s] = 1'b0;
                // a freed head slot simply stays at the head
                if (s != free_head)
                begin
                    prv = back_link[s];
                    nxt = fwd_link[s];
                    if (is_slot(prv))
                    begin
                        if (is_slot(nxt))
                        begin
                            fwd_link[prv]  = nxt;
                            back_link[nxt] = prv;
                        end
                        else
                        begin
                            busy_tail     = prv;
                            fwd_link[prv] = NIL;
                        end
                    end
                    back_link[s] = NIL;
                    if (is_slot(free_head))
                        back_link[free_head] = s;
                    fwd_link[s] = free_head;
                    free_head   = s;
                end
                if (busy_count > 0)
                    busy_count--;
            end
        end
        ans.used_count = USED_COUNT_W'(busy_count);
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                fwd_link[i]  = (i + 1 < SLOTS) ? LINK_W'(i + 1) : NIL;
                back_link[i] = (i > 0) ? LINK_W'(i - 1) : NIL;
                slot_busy[i] = 1'b0;
            end
            free_head  = '0;
            busy_tail  = LINK_W'(SLOTS - 1);
            busy_count = 0;
            owed_rsp.delete();
            pending    = 0;
        end
        else
        begin
            // results leave before this edge's command is added
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("unexpected result: granted_slot %0d status %0d used_count %0d",
                           rsp.granted_slot, rsp.status, rsp.used_count);
                    errors++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.granted_slot !== want.granted_slot)
                    begin
                        $error("granted_slot: expected %0d, got %0d",
                               want.granted_slot, rsp.granted_slot);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.used_count !== want.used_count)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, rsp.used_count);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                owed_rsp.push_back(pool_step(req));
            pending = owed_rsp.size();
        end
    end

endmodule

### tb/tb_top.sv
// testbench top for the slot pool allocator: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slpa_pkg::*;

    localparam int RANDOM_ROUNDS = 35;
    localparam int ROUND_ITEMS   = 50;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 300;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   errors;
    int   pending;
    bit   gaps_on   = 1'b1;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    slot_pool_allocator_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    slpa_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    task automatic send_req(input cmd_t c, input logic [SLOT_INDEX_W-1:0] idx);
        int   gap;
        req_t item;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        item.cmd        = c;
        item.slot_index = idx;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
    endtask

    // result side: random stall per transfer, one long hold-off to back up the pool
    initial
    begin
        int taken;
        int stall;
        taken = 0;
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 13) : 0;
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            taken++;
        end
    end

    initial
    begin
        int acq_pct;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // release of a slot never handed out
        send_req(CMD_RELEASE, 4'd9);
        // fill the pool, then one acquire too many
        repeat (SLOTS_DEFAULT) send_req(CMD_ACQUIRE, 4'd0);
        send_req(CMD_ACQUIRE, 4'd0);
        // the last grant was moved to the tail: free it, then free it again
        send_req(CMD_RELEASE, 4'd15);
        send_req(CMD_RELEASE, 4'd15);
        // unlink from the middle and from the front of the used run
        send_req(CMD_RELEASE, 4'd7);
        send_req(CMD_RELEASE, 4'd0);
        // freed slots come back last in, first out
        send_req(CMD_ACQUIRE, 4'd15);
        send_req(CMD_ACQUIRE, 4'd6);

        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            case ($urandom_range(0, 3))
                0:       acq_pct = 15;
                3:       acq_pct = 90;
                default: acq_pct = 50;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (ROUND_ITEMS)
                send_req(($urandom_range(0, 99) < acq_pct) ? CMD_ACQUIRE : CMD_RELEASE,
                         SLOT_INDEX_W'($urandom_range(0, 15)));
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
